[rtl/pfdm_pkg.sv]
// ----------------------------------------------------------------------------
// pfdm_pkg: shared types and constants of the pulse frequency/duty meter
// Field widths, register indexes, limits and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none
package pfdm_pkg;
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W  = 3;
  localparam int TS_W  = 32;
  localparam int FRQ_W = 30;
  localparam int DTY_W = 14;
  localparam int CNT_W = 16;
  localparam int SN_W  = 8;
  localparam int ACT_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 30;
  localparam int DVD_W = 64;
  localparam int DVS_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 2'd2;

  localparam logic [FRQ_W-1:0] FREQ_MAX      = 30'd1000000000;
  localparam logic [DTY_W-1:0] DUTY_MAX      = 14'd10000;
  localparam logic [32:0]      STALE_DEFAULT = 33'd2000000;
  localparam logic [FRQ_W-1:0] THR_MIN       = 30'd100;
  localparam logic [SN_W-1:0]  SN_RESET      = 8'd4;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/pfdm_if.sv]
// ----------------------------------------------------------------------------
// pfdm_in_if / pfdm_out_if: valid/ready channels of the meter
// Sample items in, measurement items out.
// ----------------------------------------------------------------------------
`default_nettype none
interface pfdm_in_if;
  logic                      valid;
  logic                      ready;
  logic [pfdm_pkg::CH_W-1:0] channel;
  logic                      level;
  logic [pfdm_pkg::TS_W-1:0] timestamp_us;
  modport source (output valid, channel, level, timestamp_us, input ready);
  modport sink   (input valid, channel, level, timestamp_us, output ready);
endinterface

interface pfdm_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfdm_pkg::CH_W-1:0]  out_channel;
  logic [pfdm_pkg::FRQ_W-1:0] freq_mhz;
  logic [pfdm_pkg::DTY_W-1:0] duty_centipct;
  logic                       rise_edge;
  logic                       fall_edge;
  logic                       is_stale;
  modport source (output valid, out_channel, freq_mhz, duty_centipct, rise_edge,
                  fall_edge, is_stale, input ready);
  modport sink   (input valid, out_channel, freq_mhz, duty_centipct, rise_edge,
                  fall_edge, is_stale, output ready);
endinterface
`default_nettype wire

[rtl/pulse_frequency_duty_meter_top.sv]
// Sequence: an inactive channel goes straight to the output register; an active one
//   runs edge step, stale check and writeback, plus the stale-limit and both quotient divisions.
// Throughput: one item at a time; the bit-serial divider (64 steps per quotient)
//   sets the rate, up to three divisions per item, plus any output stall.
// Reset (synchronous, rst_n low): all channel state, held values, configuration
//   and the divider request return to their defaults; no result is pending.
// ----------------------------------------------------------------------------
// pulse_frequency_duty_meter_top: multi-channel pulse frequency/duty meter
// Edge detection, accumulation, stale timeout and serial division per sample.
// ----------------------------------------------------------------------------
`default_nettype none
module pulse_frequency_duty_meter_top (
  input  wire                              clk,
  input  wire                              rst_n,
  pfdm_in_if.sink                          in_bus,
  pfdm_out_if.source                       out_bus,
  input  wire                              cfg_we,
  input  wire [pfdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [pfdm_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  localparam int N = pfdm_pkg::NUM_CHANNELS;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_LIM, S_STALE, S_FDIV, S_MUL1, S_MUL2, S_DDIV, S_WB, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [pfdm_pkg::SN_W-1:0]  sn_r;
  logic [pfdm_pkg::FRQ_W-1:0] thr_r;
  logic [pfdm_pkg::ACT_W-1:0] act_r;

  // per-channel state
  logic                       lvl_a  [N];
  logic                       known_a[N];
  logic                       seen_a [N];
  logic [31:0]                let_a  [N];
  logic [31:0]                lrt_a  [N];
  logic [31:0]                ps_a   [N];
  logic [31:0]                hs_a   [N];
  logic [15:0]                pc_a   [N];
  logic [15:0]                hc_a   [N];
  logic [pfdm_pkg::FRQ_W-1:0] hf_a   [N];
  logic [pfdm_pkg::DTY_W-1:0] hd_a   [N];

  // item and working registers
  logic [pfdm_pkg::CH_W-1:0]  ch_r;
  logic                       lvl_r;
  logic [31:0]                ts_r;
  logic [31:0]                let_r, ps_r, hs_r;
  logic [15:0]                pc_r, hc_r;
  logic                       rise_r, fall_r, stale_r, clr_r;
  logic [32:0]                limit_r;
  logic [47:0]                tmp_r;
  logic [pfdm_pkg::FRQ_W-1:0] hf_r;
  logic [pfdm_pkg::DTY_W-1:0] hd_r;

  // output register
  logic                       out_valid_r;
  logic [pfdm_pkg::CH_W-1:0]  o_ch_r;
  logic [pfdm_pkg::FRQ_W-1:0] o_f_r;
  logic [pfdm_pkg::DTY_W-1:0] o_d_r;
  logic                       o_rise_r, o_fall_r, o_stale_r;

  pfdm_pkg::div_req_t div_req_r;
  pfdm_pkg::div_rsp_t div_rsp;

  pfdm_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .rsp(div_rsp));

  // edge step on the current channel
  logic        e_known, e_ll, e_seen, e_rise, e_fall, e_level_diff;
  logic [31:0] e_let, e_lrt, e_ps, e_hs, e_dt;
  logic [15:0] e_pc, e_hc;
  logic [32:0] e_sum;
  always_comb begin
    e_known = known_a[ch_r];
    e_ll    = lvl_a[ch_r];
    e_seen  = seen_a[ch_r];
    e_let   = let_a[ch_r];
    e_lrt   = lrt_a[ch_r];
    e_ps    = ps_a[ch_r];
    e_hs    = hs_a[ch_r];
    e_pc    = pc_a[ch_r];
    e_hc    = hc_a[ch_r];
    e_rise  = 1'b0;
    e_fall  = 1'b0;
    e_dt    = ts_r - lrt_a[ch_r];
    e_level_diff = (lvl_r != e_ll);
    e_sum   = {1'b0, lvl_r ? e_ps : e_hs} + {1'b0, e_dt};
    if (!e_known) begin
      e_let = ts_r;
    end else if (e_level_diff) begin
      if (lvl_r) begin
        if (e_seen) begin
          e_ps = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
          e_pc = (e_pc == 16'hFFFF) ? e_pc : e_pc + 16'd1;
        end
        e_lrt  = ts_r;
        e_seen = 1'b1;
        e_rise = 1'b1;
      end else begin
        if (e_seen) begin
          e_hs = e_sum[32] ? 32'hFFFF_FFFF : e_sum[31:0];
          e_hc = (e_hc == 16'hFFFF) ? e_hc : e_hc + 16'd1;
        end
        e_fall = 1'b1;
      end
      e_let = ts_r;
    end
  end

  logic [31:0] diff;
  assign diff = ts_r - let_r;

  assign in_bus.ready          = (state_r == S_IDLE);
  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_channel   = o_ch_r;
  assign out_bus.freq_mhz      = o_f_r;
  assign out_bus.duty_centipct = o_d_r;
  assign out_bus.rise_edge     = o_rise_r;
  assign out_bus.fall_edge     = o_fall_r;
  assign out_bus.is_stale      = o_stale_r;

  // sequencer, channel state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sn_r        <= pfdm_pkg::SN_RESET;
      thr_r       <= '0;
      act_r       <= '0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
      for (int i = 0; i < N; i++) begin
        lvl_a[i] <= 1'b0; known_a[i] <= 1'b0; seen_a[i] <= 1'b0;
        let_a[i] <= '0;   lrt_a[i]   <= '0;   ps_a[i]   <= '0;
        hs_a[i]  <= '0;   pc_a[i]    <= '0;   hc_a[i]   <= '0;
        hf_a[i]  <= '0;   hd_a[i]    <= '0;
      end
    end else begin
      div_req_r.start <= 1'b0;
      if (out_valid_r && out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          pfdm_pkg::REG_SAMPLES:   sn_r  <= cfg_wdata[pfdm_pkg::SN_W-1:0];
          pfdm_pkg::REG_THRESHOLD: thr_r <= cfg_wdata;
          pfdm_pkg::REG_ACTIVE:    act_r <= cfg_wdata[pfdm_pkg::ACT_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            ch_r    <= in_bus.channel;
            lvl_r   <= in_bus.level;
            ts_r    <= in_bus.timestamp_us;
            rise_r  <= 1'b0;
            fall_r  <= 1'b0;
            stale_r <= 1'b0;
            hf_r    <= '0;
            hd_r    <= '0;
            state_r <= ({1'b0, in_bus.channel} >= act_r) ? S_DONE : S_EDGE;
          end
        end
        S_EDGE: begin
          known_a[ch_r] <= 1'b1;
          lvl_a[ch_r]   <= lvl_r;
          seen_a[ch_r]  <= e_seen;
          lrt_a[ch_r]   <= e_lrt;
          let_a[ch_r]   <= e_let;
          let_r  <= e_let;
          ps_r   <= e_ps;
          hs_r   <= e_hs;
          pc_r   <= e_pc;
          hc_r   <= e_hc;
          rise_r <= e_rise;
          fall_r <= e_fall;
          hf_r   <= hf_a[ch_r];
          hd_r   <= hd_a[ch_r];
          clr_r  <= 1'b0;
          if (thr_r > pfdm_pkg::THR_MIN) begin
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= 64'(pfdm_pkg::FREQ_MAX);
            div_req_r.divisor  <= 48'(thr_r);
            state_r <= S_LIM;
          end else begin
            limit_r <= pfdm_pkg::STALE_DEFAULT;
            state_r <= S_STALE;
          end
        end
        S_LIM: begin
          if (div_rsp.done) begin
            limit_r <= {div_rsp.quotient[31:0], 1'b0};
            state_r <= S_STALE;
          end
        end
        S_STALE: begin
          if ({1'b0, diff} > limit_r) begin
            stale_r <= 1'b1;
            clr_r   <= 1'b1;
            hf_r    <= '0;
            hd_r    <= '0;
            state_r <= S_WB;
          end else if (pc_r >= 16'(sn_r) && hc_r >= 16'(sn_r)) begin
            clr_r <= 1'b1;
            if (ps_r == '0 || pc_r == '0) begin
              hf_r    <= '0;
              hd_r    <= '0;
              state_r <= S_WB;
            end else begin
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= 64'(pfdm_pkg::FREQ_MAX) * 64'(pc_r);
              div_req_r.divisor  <= 48'(ps_r);
              state_r <= S_FDIV;
            end
          end else begin
            state_r <= S_WB;
          end
        end
        S_FDIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient < 64'(thr_r)) begin
              hf_r    <= '0;
              hd_r    <= '0;
              state_r <= S_WB;
            end else begin
              hf_r <= (div_rsp.quotient > 64'(pfdm_pkg::FREQ_MAX))
                      ? pfdm_pkg::FREQ_MAX : div_rsp.quotient[pfdm_pkg::FRQ_W-1:0];
              hd_r <= '0;
              state_r <= (hc_r == '0) ? S_WB : S_MUL1;
            end
          end
        end
        S_MUL1: begin
          tmp_r   <= hs_r * pc_r;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          div_req_r.start    <= 1'b1;
          div_req_r.dividend <= 64'(tmp_r) * 64'(pfdm_pkg::DUTY_MAX);
          div_req_r.divisor  <= hc_r * ps_r;
          state_r <= S_DDIV;
        end
        S_DDIV: begin
          if (div_rsp.done) begin
            hd_r <= (div_rsp.quotient > 64'(pfdm_pkg::DUTY_MAX))
                    ? pfdm_pkg::DUTY_MAX : div_rsp.quotient[pfdm_pkg::DTY_W-1:0];
            state_r <= S_WB;
          end
        end
        S_WB: begin
          ps_a[ch_r] <= clr_r ? '0 : ps_r;
          hs_a[ch_r] <= clr_r ? '0 : hs_r;
          pc_a[ch_r] <= clr_r ? '0 : pc_r;
          hc_a[ch_r] <= clr_r ? '0 : hc_r;
          hf_a[ch_r] <= hf_r;
          hd_a[ch_r] <= hd_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          // hand the item to the output register once it is free
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            o_ch_r      <= ch_r;
            o_f_r       <= hf_r;
            o_d_r       <= hd_r;
            o_rise_r    <= rise_r;
            o_fall_r    <= fall_r;
            o_stale_r   <= stale_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/pfdm_div.sv]
// ----------------------------------------------------------------------------
// pfdm_div: bit-serial restoring divider
// One quotient bit per cycle while busy, from start until done.
// ----------------------------------------------------------------------------
`default_nettype none
module pfdm_div (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire pfdm_pkg::div_req_t req,
  output pfdm_pkg::div_rsp_t  rsp
);
  logic                         busy_r;
  logic                         done_r;
  logic [6:0]                   cnt_r;
  logic [pfdm_pkg::DVD_W-1:0]   dvd_r;
  logic [pfdm_pkg::DVS_W-1:0]   rem_r;
  logic [pfdm_pkg::DVS_W-1:0]   dvs_r;
  logic [pfdm_pkg::DVS_W:0]     trial;
  logic                         qbit;

  // trial subtract of the next dividend bit
  assign trial = {rem_r, dvd_r[pfdm_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? pfdm_pkg::DVS_W'(trial - {1'b0, dvs_r})
                      : trial[pfdm_pkg::DVS_W-1:0];
        dvd_r <= {dvd_r[pfdm_pkg::DVD_W-2:0], qbit};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(pfdm_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;
endmodule
`default_nettype wire

[dv/pulse_frequency_duty_meter_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_frequency_duty_meter_top_tb: self-checking bench of the pulse meter
// Streams per-channel square waves with wrapping microsecond timestamps,
// stale gaps and noise through several register settings, predicts every
// measurement item and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
module pulse_frequency_duty_meter_top_tb;

  typedef struct {
    logic [pfdm_pkg::CH_W-1:0] ch;
    logic                      lvl;
    logic [pfdm_pkg::TS_W-1:0] ts;
  } sample_t;

  typedef struct {
    logic [pfdm_pkg::CH_W-1:0]  ch;
    logic [pfdm_pkg::FRQ_W-1:0] freq;
    logic [pfdm_pkg::DTY_W-1:0] duty;
    logic                       rise;
    logic                       fall;
    logic                       stale;
  } meas_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [pfdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pfdm_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  pfdm_in_if  in_bus ();
  pfdm_out_if out_bus ();

  pulse_frequency_duty_meter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  sample_t pend_q[$];
  meas_t   meas_q[$];
  int      n_err = 0;
  bit      calm = 1'b0;

  // Shadow of the registers and per-channel meter state
  int unsigned sn_r, thr_r, act_r;
  bit                        lvl_m   [pfdm_pkg::NUM_CHANNELS];
  bit                        known_m [pfdm_pkg::NUM_CHANNELS];
  bit                        rseen_m [pfdm_pkg::NUM_CHANNELS];
  bit [31:0]                 edge_tm [pfdm_pkg::NUM_CHANNELS];
  bit [31:0]                 rise_tm [pfdm_pkg::NUM_CHANNELS];
  bit [31:0]                 psum    [pfdm_pkg::NUM_CHANNELS];
  bit [31:0]                 hsum    [pfdm_pkg::NUM_CHANNELS];
  bit [15:0]                 pcnt    [pfdm_pkg::NUM_CHANNELS];
  bit [15:0]                 hcnt    [pfdm_pkg::NUM_CHANNELS];
  bit [pfdm_pkg::FRQ_W-1:0]  hfreq   [pfdm_pkg::NUM_CHANNELS];
  bit [pfdm_pkg::DTY_W-1:0]  hduty   [pfdm_pkg::NUM_CHANNELS];

  // Reset the shadow meter
  task automatic meter_clear();
    sn_r = pfdm_pkg::SN_RESET; thr_r = 0; act_r = 0;
    for (int i = 0; i < pfdm_pkg::NUM_CHANNELS; i++) begin
      lvl_m[i] = 0; known_m[i] = 0; rseen_m[i] = 0; edge_tm[i] = 0; rise_tm[i] = 0;
      psum[i] = 0; hsum[i] = 0; pcnt[i] = 0; hcnt[i] = 0; hfreq[i] = 0; hduty[i] = 0;
    end
  endtask

  function automatic bit [31:0] sat32(bit [31:0] a, bit [31:0] b);
    bit [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic longint unsigned stale_limit(int unsigned thr);
    return (thr > pfdm_pkg::THR_MIN) ? 2 * (64'd1000000000 / thr) : 64'd2000000;
  endfunction

  // Measurement item that one sample yields; advances the shadow state
  function automatic void measure_sample(sample_t s);
    meas_t r;
    int c;
    longint unsigned f, d, num, den;
    bit [31:0] gap;
    r = '{ch: s.ch, freq: '0, duty: '0, rise: 0, fall: 0, stale: 0};
    c = s.ch;
    if (c < act_r && c < pfdm_pkg::NUM_CHANNELS) begin
      if (!known_m[c]) begin
        known_m[c] = 1; lvl_m[c] = s.lvl; edge_tm[c] = s.ts;
      end else if (s.lvl != lvl_m[c]) begin
        if (s.lvl) begin
          if (rseen_m[c]) begin
            psum[c] = sat32(psum[c], s.ts - rise_tm[c]);
            if (pcnt[c] != 16'hFFFF) pcnt[c]++;
          end
          rise_tm[c] = s.ts; rseen_m[c] = 1; r.rise = 1;
        end else begin
          if (rseen_m[c]) begin
            hsum[c] = sat32(hsum[c], s.ts - rise_tm[c]);
            if (hcnt[c] != 16'hFFFF) hcnt[c]++;
          end
          r.fall = 1;
        end
        lvl_m[c] = s.lvl; edge_tm[c] = s.ts;
      end
      gap = s.ts - edge_tm[c];
      if (64'(gap) > stale_limit(thr_r)) begin
        psum[c] = 0; hsum[c] = 0; pcnt[c] = 0; hcnt[c] = 0;
        hfreq[c] = 0; hduty[c] = 0; r.stale = 1;
      end else if (pcnt[c] >= sn_r && hcnt[c] >= sn_r) begin
        if (psum[c] == 0 || pcnt[c] == 0) begin
          hfreq[c] = 0; hduty[c] = 0;
        end else begin
          f = (64'd1000000000 * pcnt[c]) / psum[c];
          if (f < thr_r) begin
            hfreq[c] = 0; hduty[c] = 0;
          end else begin
            d = 0;
            if (f > pfdm_pkg::FREQ_MAX) f = pfdm_pkg::FREQ_MAX;
            if (hcnt[c] != 0) begin
              num = 64'd10000 * hsum[c] * pcnt[c];
              den = 64'(hcnt[c]) * psum[c];
              d = num / den;
              if (d > pfdm_pkg::DUTY_MAX) d = pfdm_pkg::DUTY_MAX;
            end
            hfreq[c] = f[pfdm_pkg::FRQ_W-1:0]; hduty[c] = d[pfdm_pkg::DTY_W-1:0];
          end
        end
        psum[c] = 0; hsum[c] = 0; pcnt[c] = 0; hcnt[c] = 0;
      end
      r.freq = hfreq[c]; r.duty = hduty[c];
    end
    meas_q.push_back(r);
  endfunction

  // Sample driver: predict at acceptance, present the next pending item
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.channel <= '0; in_bus.level <= 1'b0; in_bus.timestamp_us <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        measure_sample('{ch: in_bus.channel, lvl: in_bus.level, ts: in_bus.timestamp_us});
      if (!in_bus.valid || in_bus.ready) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          s = pend_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.channel <= s.ch; in_bus.level <= s.lvl; in_bus.timestamp_us <= s.ts;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, check each item against the oldest one due
  always @(posedge clk) begin
    meas_t e;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (meas_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected item on channel %0d", out_bus.out_channel);
        end else begin
          e = meas_q.pop_front();
          if (out_bus.out_channel !== e.ch || out_bus.freq_mhz !== e.freq ||
              out_bus.duty_centipct !== e.duty || out_bus.rise_edge !== e.rise ||
              out_bus.fall_edge !== e.fall || out_bus.is_stale !== e.stale) begin
            n_err++;
            if (n_err <= 10)
              $display({"mismatch exp ch%0d f%0d d%0d r%0b f%0b s%0b",
                        " got ch%0d f%0d d%0d r%0b f%0b s%0b"},
                       e.ch, e.freq, e.duty, e.rise, e.fall, e.stale,
                       out_bus.out_channel, out_bus.freq_mhz, out_bus.duty_centipct,
                       out_bus.rise_edge, out_bus.fall_edge, out_bus.is_stale);
          end
        end
      end
      out_bus.ready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic push(int ch, bit lvl, bit [31:0] ts);
    pend_q.push_back('{ch: ch[pfdm_pkg::CH_W-1:0], lvl: lvl, ts: ts});
  endtask

  // Write one register while the block is idle
  task automatic reg_write(logic [pfdm_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val[pfdm_pkg::CFG_DAT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfdm_pkg::REG_SAMPLES:   sn_r = val & 8'hFF;
      pfdm_pkg::REG_THRESHOLD: thr_r = val & 30'h3FFF_FFFF;
      pfdm_pkg::REG_ACTIVE:    act_r = val & 4'hF;
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned sn, int unsigned thr, int unsigned act);
    reg_write(pfdm_pkg::REG_SAMPLES, sn);
    reg_write(pfdm_pkg::REG_THRESHOLD, thr);
    reg_write(pfdm_pkg::REG_ACTIVE, act);
  endtask

  // Drain all pending and expected items, then let the divider settle
  task automatic drain();
    while (pend_q.size() != 0 || meas_q.size() != 0 || in_bus.valid) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // Random square waves per channel, with stale gaps, resamples and noise
  task automatic wave_phase(int n);
    bit [31:0] t [pfdm_pkg::NUM_CHANNELS];
    bit lv [pfdm_pkg::NUM_CHANNELS];
    int unsigned per [pfdm_pkg::NUM_CHANNELS], hi [pfdm_pkg::NUM_CHANNELS];
    int unsigned pmax, ch, k, step;
    longint unsigned lim;
    lim = stale_limit(thr_r);
    pmax = (thr_r > pfdm_pkg::THR_MIN) ? 1000000000 / thr_r : 100000;
    if (pmax == 0) pmax = 1;
    for (int i = 0; i < pfdm_pkg::NUM_CHANNELS; i++) begin
      t[i] = $urandom; lv[i] = $urandom_range(0, 1);
      per[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2 * pmax)
                                          : $urandom_range(1, pmax);
      hi[i] = $urandom_range(0, per[i]);
    end
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(0, pfdm_pkg::NUM_CHANNELS - 1);
      k = $urandom_range(0, 99);
      if (k < 70) begin
        step = lv[ch] ? hi[ch] : per[ch] - hi[ch];
        if ($urandom_range(0, 7) == 0 && step > 0) step = step - 1 + $urandom_range(0, 2);
        t[ch] += step; lv[ch] = ~lv[ch];
      end else if (k < 82) begin
        t[ch] += $urandom_range(0, 1 + hi[ch] / 2);
      end else if (k < 90) begin
        t[ch] += 32'(lim) + $urandom_range(1, 1000); lv[ch] = ~lv[ch];
      end else if (k < 94) begin
        per[ch] = $urandom_range(0, pmax); hi[ch] = $urandom_range(0, per[ch] + 3);
      end else begin
        t[ch] = $urandom; lv[ch] = $urandom_range(0, 1);
      end
      push(ch, lv[ch], t[ch]);
    end
  endtask

  initial begin
    meter_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every channel off after reset
    push(0, 1, 32'hFFFF_FFFF); push(7, 0, 32'h0);
    drain();
    setup(1, 0, 8);
    // Fall before first rise, first rise, update across the timestamp wrap
    push(0, 1, 32'hFFFF_FFF0); push(0, 0, 32'hFFFF_FFF4); push(0, 1, 32'hFFFF_FFF8);
    push(0, 0, 32'hFFFF_FFFC); push(0, 1, 32'h0000_0004); push(0, 1, 32'h0000_0005);
    // Zero period sum
    push(1, 0, 32'd100); push(1, 1, 32'd200); push(1, 0, 32'd200); push(1, 1, 32'd200);
    // Duty above full scale, then a long gap that ends in edges and so is not stale
    push(2, 0, 32'd0); push(2, 1, 32'd10); push(2, 0, 32'd40); push(2, 1, 32'd20);
    push(2, 0, 32'd3000000); push(2, 1, 32'd3000001);
    push(7, 1, 32'hFFFF_FFFF); push(7, 0, 32'hFFFF_FFFF);
    drain();
    setup(2, 1000000000, 8);
    push(3, 0, 32'd0); push(3, 1, 32'd1); push(3, 0, 32'd2); push(3, 1, 32'd3);
    push(3, 0, 32'd3); push(3, 1, 32'd4); push(3, 0, 32'd5); push(3, 1, 32'd9);
    drain();

    // Random phases over several settings
    setup(4, 0, 8);        wave_phase(200); drain();
    setup(1, 100, 8);      calm = 1'b1; wave_phase(200); drain(); calm = 1'b0;
    setup(2, 101, 5);      wave_phase(200); drain();
    setup(3, 20000, 8);    wave_phase(200); drain();
    setup(1, 1000000000, 8); wave_phase(150); drain();
    setup(255, 0, 8);      wave_phase(150); drain();
    setup(2, 5000, 3);     wave_phase(200); drain();
    setup(1, 0, 0);        wave_phase(50); drain();
    setup(3, 50, 8);       wave_phase(200); drain();

    if (n_err == 0 && meas_q.size() == 0) begin
      $display("pulse_frequency_duty_meter_top_tb: PASS");
    end else begin
      $display("pulse_frequency_duty_meter_top_tb: FAIL");
    end
    $finish;
  end

  // Hard stop on a hung handshake
  initial begin
    #50ms;
    $display("pulse_frequency_duty_meter_top_tb: FAIL");
    $finish;
  end
endmodule
